@@ design/ctt_pkg.sv @@
// package for the connection table with idle timeout
// types, codes and sizes shared by the front, back and top level
`timescale 1ns / 1ps
package ctt_pkg;
    localparam int Slots = 16;
    localparam int IdxW = (Slots > 1) ? $clog2(Slots) : 1;
    localparam int IdW = 7;
    localparam int QDepth = 2;

    typedef enum logic [2:0] {
        K_ADD = 3'd0, K_RM_ID = 3'd1, K_RM_EP = 3'd2, K_LOOKUP = 3'd3,
        K_ACT = 3'd4, K_SWEEP = 3'd5, K_PING_RPL = 3'd6, K_PING_RD = 3'd7
    } t_kind;

    localparam logic [IdW-1:0] CfgLimit = 7'd0;
    localparam logic [IdW-1:0] CfgTimeout = 7'd1;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] ip_address;
        logic [15:0] port_number;
        logic [IdW-1:0] conn_id;
        logic        id_ok;
        logic [31:0] now;
        logic [31:0] diff;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EMIT, S_DONE
    } t_state;
endpackage

@@ design/ctt_front.sv @@
// front part: accepts input beats, checks the id and works out the ping difference
// depends on ctt_pkg
`timescale 1ns / 1ps
module ctt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_kind,
    input  logic [31:0]         i_ip_address,
    input  logic [15:0]         i_port_number,
    input  logic [6:0]          i_conn_id,
    input  logic [31:0]         i_now,
    input  logic [31:0]         i_sent_time,
    output logic                o_q_valid,
    input  logic                i_q_pop,
    output ctt_pkg::t_cmd       o_q_cmd
);
    import ctt_pkg::*;
    t_cmd r_q [QDepth];
    logic [1:0] r_cnt, n_cnt;
    logic r_wp, r_rp;
    logic push;
    t_cmd c;

    always_comb begin
        c.kind = t_kind'(i_kind);
        c.ip_address = i_ip_address;
        c.port_number = i_port_number;
        c.conn_id = i_conn_id;
        c.id_ok = (i_conn_id != '0) && (i_conn_id <= IdW'(Slots));
        c.now = i_now;
        c.diff = i_now - i_sent_time;
    end

    assign o_ready = (r_cnt != 2'(QDepth));
    assign push = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd = r_q[r_rp];
    assign n_cnt = r_cnt + 2'(push) - 2'(i_q_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
        end
        if (push) r_q[r_wp] <= c;
    end
endmodule

@@ design/ctt_back.sv @@
// back: scans slots one a cycle, pausing on sweep drops; builds result beats
// depends on ctt_pkg
`timescale 1ns / 1ps
module ctt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  ctt_pkg::t_cmd       i_q_cmd,
    input  logic [6:0]          i_slot_limit,
    input  logic [31:0]         i_idle_timeout,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [6:0]          o_result_id,
    output logic                o_timed_out,
    output logic [31:0]         o_ping_value,
    output logic [31:0]         o_idle_time,
    output logic [6:0]          o_live_count,
    output logic                o_last
);
    import ctt_pkg::*;
    t_state r_st, n_st;
    logic [Slots-1:0] r_used;
    logic [31:0] r_addr [Slots];
    logic [15:0] r_port [Slots];
    logic [31:0] r_seen [Slots];
    logic [31:0] r_rtt [Slots];
    logic [IdW-1:0] r_cnt;
    logic [IdxW-1:0] r_i;
    logic r_found;
    t_cmd r_cmd;
    logic [IdW-1:0] r_wid;
    logic [31:0] r_widle;
    logic [IdW-1:0] r_oid, r_ocnt;
    logic r_oto, r_olast, r_ov;
    logic [31:0] r_oping, r_oidle;

    logic [IdW-1:0] lim, id_i;
    logic [IdxW-1:0] sel;
    logic [31:0] idiff;
    logic hit, last_i, fin, emit_go;

    assign lim = (i_slot_limit == '0 || i_slot_limit > IdW'(Slots)) ? IdW'(Slots)
                                                                    : i_slot_limit;
    assign id_i = IdW'(r_i) + IdW'(1);
    assign sel = IdxW'(r_cmd.conn_id - IdW'(1));
    assign idiff = r_cmd.now - r_seen[r_i];
    assign last_i = (id_i == IdW'(Slots));

    always_comb begin
        hit = 1'b0;
        case (r_cmd.kind)
            K_ADD:   hit = !r_used[r_i] && (id_i <= lim);
            K_RM_EP, K_LOOKUP:
                hit = r_used[r_i] && r_addr[r_i] == r_cmd.ip_address
                      && r_port[r_i] == r_cmd.port_number;
            K_SWEEP: hit = r_used[r_i] && (idiff > i_idle_timeout);
            default: hit = 1'b0;
        endcase
    end

    assign fin = !r_ov || i_ready;
    assign emit_go = (r_st == S_EMIT || r_st == S_DONE) && fin;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_q_valid) n_st = S_SCAN;
            S_SCAN: begin
                if (r_cmd.kind == K_SWEEP) begin
                    if (hit) n_st = S_EMIT;
                    else if (last_i) n_st = S_DONE;
                end else if (r_cmd.kind == K_ADD || r_cmd.kind == K_RM_EP
                             || r_cmd.kind == K_LOOKUP) begin
                    if (hit || last_i) n_st = S_DONE;
                end else begin
                    n_st = S_DONE;
                end
            end
            S_EMIT: if (fin) n_st = last_i ? S_DONE : S_SCAN;
            S_DONE: if (fin) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_st == S_IDLE) && i_q_valid;
    end

    assign o_valid = r_ov;
    assign o_result_id = r_oid;
    assign o_timed_out = r_oto;
    assign o_ping_value = r_oping;
    assign o_idle_time = r_oidle;
    assign o_live_count = r_ocnt;
    assign o_last = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_used <= '0;
            r_cnt <= '0;
            r_ov <= 1'b0;
            r_i <= '0;
            r_found <= 1'b0;
            for (int k = 0; k < Slots; k++) begin
                r_seen[k] <= '0;
                r_rtt[k] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (emit_go) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_cmd <= i_q_cmd;
                    r_i <= '0;
                    r_found <= 1'b0;
                    r_wid <= '0;
                end
                S_SCAN: begin
                    case (r_cmd.kind)
                        K_ADD: if (hit) begin
                            r_used[r_i] <= 1'b1;
                            r_addr[r_i] <= r_cmd.ip_address;
                            r_port[r_i] <= r_cmd.port_number;
                            r_cnt <= r_cnt + IdW'(1);
                            r_wid <= id_i;
                        end else r_i <= r_i + IdxW'(!last_i);
                        K_RM_EP: if (hit) begin
                            r_used[r_i] <= 1'b0;
                            r_cnt <= r_cnt - IdW'(1);
                            r_wid <= id_i;
                        end else r_i <= r_i + IdxW'(!last_i);
                        K_LOOKUP: if (hit) r_wid <= id_i;
                                  else r_i <= r_i + IdxW'(!last_i);
                        K_SWEEP: if (hit) begin
                            r_used[r_i] <= 1'b0;
                            r_cnt <= r_cnt - IdW'(1);
                            r_wid <= id_i;
                            r_widle <= idiff;
                        end else if (!last_i) r_i <= r_i + IdxW'(1);
                        K_RM_ID: if (r_cmd.id_ok && r_used[sel]) begin
                            r_used[sel] <= 1'b0;
                            r_cnt <= r_cnt - IdW'(1);
                            r_wid <= r_cmd.conn_id;
                        end
                        K_ACT: if (r_cmd.id_ok) begin
                            r_seen[sel] <= r_cmd.now;
                            r_wid <= r_cmd.conn_id;
                        end
                        K_PING_RPL: if (r_cmd.id_ok) begin
                            r_rtt[sel] <= r_cmd.diff;
                            r_wid <= r_cmd.conn_id;
                        end
                        default: if (r_cmd.id_ok) r_wid <= r_cmd.conn_id;
                    endcase
                end
                S_EMIT: if (fin) begin
                    // emit with last clear; ctt_drop_buf holds it to mark last
                    r_oid <= r_wid;
                    r_oto <= 1'b1;
                    r_oping <= '0;
                    r_oidle <= r_widle;
                    r_ocnt <= r_cnt;
                    r_olast <= 1'b0;
                    r_found <= 1'b1;
                    r_i <= r_i + IdxW'(!last_i);
                end
                S_DONE: if (fin) begin
                    r_olast <= 1'b1;
                    r_ocnt <= r_cnt;
                    r_oid <= r_wid;
                    if (r_cmd.kind == K_SWEEP) begin
                        r_oto <= r_found;
                        r_oidle <= r_found ? r_widle : '0;
                        r_oping <= '0;
                    end else begin
                        r_oto <= 1'b0;
                        r_oidle <= '0;
                        r_oping <= (r_cmd.id_ok && (r_cmd.kind == K_PING_RPL
                                    || r_cmd.kind == K_PING_RD)) ? r_rtt[sel] : '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

@@ design/ctt_drop_buf.sv @@
// one-beat holding stage so a sweep can mark its final drop as last
// depends on ctt_pkg
`timescale 1ns / 1ps
module ctt_drop_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [6:0]    i_result_id,
    input  logic          i_timed_out,
    input  logic [31:0]   i_ping_value,
    input  logic [31:0]   i_idle_time,
    input  logic [6:0]    i_live_count,
    input  logic          i_last,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [6:0]    o_result_id,
    output logic          o_timed_out,
    output logic [31:0]   o_ping_value,
    output logic [31:0]   o_idle_time,
    output logic [6:0]    o_live_count,
    output logic          o_last
);
    import ctt_pkg::*;
    // a held drop is released when the next beat arrives; a bare done beat
    // after a drop only turns the held drop into last
    logic r_hv, r_ov;
    logic [6:0] r_hid, r_hcnt, r_oid, r_ocnt;
    logic [31:0] r_hidle, r_oping, r_oidle;
    logic r_oto, r_olast;
    logic out_free, take, dup, load;

    assign out_free = !r_ov || i_ready;
    assign o_ready = out_free;
    assign take = i_valid && out_free;
    assign dup = i_last && i_timed_out && r_hv;
    assign load = take && !(i_timed_out && !i_last && !r_hv);

    assign o_valid = r_ov;
    assign o_result_id = r_oid;
    assign o_timed_out = r_oto;
    assign o_ping_value = r_oping;
    assign o_idle_time = r_oidle;
    assign o_live_count = r_ocnt;
    assign o_last = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (take) begin
                if (i_timed_out && !i_last) begin
                    if (r_hv) begin
                        r_oid <= r_hid; r_oto <= 1'b1; r_oping <= '0;
                        r_oidle <= r_hidle; r_ocnt <= r_hcnt; r_olast <= 1'b0;
                    end
                    r_hv <= 1'b1;
                    r_hid <= i_result_id; r_hidle <= i_idle_time;
                    r_hcnt <= i_live_count;
                end else if (dup) begin
                    r_hv <= 1'b0;
                    r_oid <= r_hid; r_oto <= 1'b1; r_oping <= '0;
                    r_oidle <= r_hidle; r_ocnt <= r_hcnt; r_olast <= 1'b1;
                end else begin
                    r_oid <= i_result_id; r_oto <= i_timed_out; r_oping <= i_ping_value;
                    r_oidle <= i_idle_time; r_ocnt <= i_live_count; r_olast <= i_last;
                end
            end
        end
    end
endmodule

@@ design/connection_table_with_idle_timeout.sv @@
// top level of the connection table with idle timeout
// depends on ctt_pkg, ctt_front, ctt_back and ctt_drop_buf
`timescale 1ns / 1ps
// Sixteen-entry connection table. The front takes input beats into a
// two-entry queue; the back handles one item at a time and walks the slots
// one per cycle, pausing while a sweep drop waits to go out. Add, remove
// by endpoint and lookup stop at the first hit; sweep always walks all 16
// slots and emits each drop as it finds it. Results leave through the
// back's output registers and then the drop buffer's; a sweep's drop is
// held one beat so it can carry last. Configuration writes are always ready.
module connection_table_with_idle_timeout (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_ip_address,
    input  logic [15:0] i_port_number,
    input  logic [6:0]  i_conn_id,
    input  logic [31:0] i_now,
    input  logic [31:0] i_sent_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_result_id,
    output logic        o_timed_out,
    output logic [31:0] o_ping_value,
    output logic [31:0] o_idle_time,
    output logic [6:0]  o_live_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ctt_pkg::*;
    logic [6:0] r_limit;
    logic [31:0] r_timeout;
    logic q_valid, q_pop;
    t_cmd q_cmd;
    logic b_valid, b_ready, b_to, b_last;
    logic [6:0] b_id, b_cnt;
    logic [31:0] b_ping, b_idle;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
            r_timeout <= 32'd10;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CfgLimit) r_limit <= i_cfg_data[6:0];
            else if (i_cfg_index == CfgTimeout) r_timeout <= i_cfg_data;
        end
    end

    ctt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_ip_address,
        .i_port_number, .i_conn_id, .i_now, .i_sent_time,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd)
    );

    ctt_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_cmd(q_cmd),
        .i_slot_limit(r_limit), .i_idle_timeout(r_timeout),
        .o_valid(b_valid), .i_ready(b_ready), .o_result_id(b_id),
        .o_timed_out(b_to), .o_ping_value(b_ping), .o_idle_time(b_idle),
        .o_live_count(b_cnt), .o_last(b_last)
    );

    ctt_drop_buf u_buf (
        .i_clk, .i_rst_n, .i_valid(b_valid), .o_ready(b_ready),
        .i_result_id(b_id), .i_timed_out(b_to), .i_ping_value(b_ping),
        .i_idle_time(b_idle), .i_live_count(b_cnt), .i_last(b_last),
        .o_valid, .i_ready, .o_result_id, .o_timed_out, .o_ping_value,
        .o_idle_time, .o_live_count, .o_last
    );
endmodule
